// ----- sv/nrsd_pkg.sv -----
// Types, constants and amplitude tables shared by the nibble RLE sound decoder.
package nrsd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned NIB_W   = 4;
    localparam int unsigned AMP_W   = 4;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned HELD_W  = 3 * AMP_W;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOWBYTE,
        PH_DATA
    } t_phase;

    // Decoder state that the nibble step reads and updates.
    typedef struct packed {
        logic                in_escape;
        logic [TICK_W-1:0]   escape_acc;
        logic [TICK_W-1:0]   ticks_left;
        logic [HELD_W-1:0]   held_amps;
    } t_dec_state;

    typedef struct packed {
        logic [AMP_W-1:0]    amp_a;
        logic [AMP_W-1:0]    amp_b;
        logic [AMP_W-1:0]    amp_c;
        logic [TICK_W-1:0]   run_ticks;
        logic                last;
    } t_result;

    // Packed as A in bits 11..8, B in 7..4, C in 3..0.
    localparam logic [HELD_W-1:0] AMP_SOFT [16] = '{
        12'h000, 12'h500, 12'h710, 12'h820, 12'h920, 12'h952, 12'hA22, 12'hA61,
        12'hB31, 12'hB62, 12'hB74, 12'hB85, 12'hC41, 12'hC62, 12'hC80, 12'hC90
    };

    localparam logic [HELD_W-1:0] AMP_LOUD [16] = '{
        12'h000, 12'h850, 12'hA70, 12'hB90, 12'hC90, 12'hD50, 12'hDA6, 12'hDC0,
        12'hE80, 12'hEAA, 12'hECA, 12'hEDA, 12'hFB0, 12'hEEB, 12'hEED, 12'hEEE
    };

    function automatic logic [HELD_W-1:0] amp_lookup(input logic loud,
                                                     input logic [NIB_W-1:0] nib);
        return loud ? AMP_LOUD[nib] : AMP_SOFT[nib];
    endfunction

endpackage

// ----- sv/nrsd_if.sv -----
// Handshake interfaces for the decoder's byte input and run output channels.
interface nrsd_in_if;
    logic                       valid;
    logic                       ready;
    logic                       start_req;
    logic                       loud;
    logic [nrsd_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output start_req, output loud, output data_byte,
                    input ready);
    modport sink   (input valid, input start_req, input loud, input data_byte,
                    output ready);
endinterface

interface nrsd_out_if;
    logic                       valid;
    logic                       ready;
    logic [nrsd_pkg::AMP_W-1:0]  amp_a;
    logic [nrsd_pkg::AMP_W-1:0]  amp_b;
    logic [nrsd_pkg::AMP_W-1:0]  amp_c;
    logic [nrsd_pkg::TICK_W-1:0] run_ticks;
    logic                       last;

    modport source (output valid, output amp_a, output amp_b, output amp_c,
                    output run_ticks, output last, input ready);
    modport sink   (input valid, input amp_a, input amp_b, input amp_c,
                    input run_ticks, input last, output ready);
endinterface

// ----- sv/nrsd_nibble.sv -----
// One data nibble step: amplitude lookup, escape accumulation and run clipping.
module nrsd_nibble (
    input  logic [nrsd_pkg::NIB_W-1:0] i_nib,
    input  logic                       i_table_sel,
    input  nrsd_pkg::t_dec_state       i_state,
    output nrsd_pkg::t_dec_state       o_state,
    output logic                       o_emit,
    output nrsd_pkg::t_result          o_result
);
    import nrsd_pkg::*;

    logic [TICK_W-1:0] acc_shift;
    logic [TICK_W:0]   run;
    logic              clip;
    logic [TICK_W-1:0] run_out;
    logic [HELD_W-1:0] amps;

    always_comb begin
        o_state   = i_state;
        o_emit    = 1'b0;
        amps      = i_state.held_amps;
        acc_shift = {i_state.escape_acc[TICK_W-4:0], i_nib[2:0]};
        run       = (TICK_W+1)'(1);

        if (!i_state.in_escape) begin
            if (i_nib == '0) begin
                o_state.in_escape  = 1'b1;
                o_state.escape_acc = '0;
            end else begin
                amps   = amp_lookup(i_table_sel, i_nib);
                o_emit = 1'b1;
            end
        end else begin
            o_state.escape_acc = acc_shift;
            // A continuation nibble only extends the escape count.
            if (!i_nib[3]) begin
                o_state.in_escape = 1'b0;
                o_emit            = 1'b1;
                run = (TICK_W+1)'(1) + {1'b0, acc_shift + TICK_W'(2)};
            end
        end

        clip    = run >= {1'b0, i_state.ticks_left};
        run_out = clip ? i_state.ticks_left : run[TICK_W-1:0];

        if (o_emit) begin
            o_state.held_amps  = amps;
            o_state.ticks_left = i_state.ticks_left - run_out;
        end

        o_result.amp_a     = amps[HELD_W-1 -: AMP_W];
        o_result.amp_b     = amps[2*AMP_W-1 -: AMP_W];
        o_result.amp_c     = amps[AMP_W-1:0];
        o_result.run_ticks = run_out;
        o_result.last      = clip;
    end

endmodule

// ----- sv/nibble_rle_sound_decoder_top.sv -----
// Top level of the nibble RLE sound decoder.
//
// Bytes enter on i_in. A word with start_req high opens a sound: it carries
// the high byte of the tick count and latches the loud/soft table choice.
// The next word is the low count byte, and every following word holds two
// data nibbles, high nibble first. Runs leave on o_out, one word per run.
//
// Each accepted word sits in an input register; the decoder works one
// nibble per cycle from it while o_out is not stalled, a data byte high
// nibble then low nibble and a header byte in a single step. A result is
// written to the output register at the end of the cycle in which its
// nibble is worked, so a run appears on o_out in the cycle after that. A
// new byte is accepted in the same cycle the previous one finishes.
//
// When o_out stalls, the output register holds its word and the decoder
// waits; once the input register is full, i_in.ready drops. Reset empties
// both registers, leaves the decoder idle with zeroed count, escape and
// amplitude state, and bytes are ignored until a start word arrives.
module nibble_rle_sound_decoder_top (
    input  logic    i_clk,
    input  logic    i_rst_n,
    nrsd_in_if.sink    i_in,
    nrsd_out_if.source o_out
);
    import nrsd_pkg::*;

    logic              r_in_valid;
    logic              r_start;
    logic              r_loud;
    logic [BYTE_W-1:0] r_byte;
    logic              r_nib_lo, n_nib_lo;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_count_high, n_count_high;
    logic              r_table_sel, n_table_sel;
    t_dec_state        r_state, n_state;

    logic              r_out_valid;
    t_result           r_out;

    logic              out_free;
    logic              step_go;
    logic              consume;
    logic              emit;
    t_result           res;
    logic [NIB_W-1:0]  nib;
    t_dec_state        nb_state;
    logic              nb_emit;
    t_result           nb_result;
    logic [TICK_W-1:0] hdr_ticks;

    assign nib = r_nib_lo ? r_byte[NIB_W-1:0] : r_byte[BYTE_W-1 -: NIB_W];

    nrsd_nibble u_nibble (
        .i_nib       (nib),
        .i_table_sel (r_table_sel),
        .i_state     (r_state),
        .o_state     (nb_state),
        .o_emit      (nb_emit),
        .o_result    (nb_result)
    );

    assign out_free  = !r_out_valid || o_out.ready;
    assign step_go   = r_in_valid && out_free;
    assign hdr_ticks = {r_count_high, r_byte};

    always_comb begin
        n_phase      = r_phase;
        n_count_high = r_count_high;
        n_table_sel  = r_table_sel;
        n_state      = r_state;
        n_nib_lo     = r_nib_lo;
        consume      = 1'b0;
        emit         = 1'b0;
        res          = nb_result;

        if (step_go) begin
            if (r_start) begin
                n_count_high         = r_byte;
                n_table_sel          = r_loud;
                n_state.in_escape    = 1'b0;
                n_state.escape_acc   = '0;
                n_phase              = PH_LOWBYTE;
                consume              = 1'b1;
            end else begin
                case (r_phase)
                    PH_LOWBYTE: begin
                        n_state.ticks_left = hdr_ticks;
                        n_state.in_escape  = 1'b0;
                        n_state.escape_acc = '0;
                        consume            = 1'b1;
                        if (hdr_ticks == '0) begin
                            // An empty sound still reports one final run.
                            n_phase       = PH_IDLE;
                            emit          = 1'b1;
                            res.amp_a     = r_state.held_amps[HELD_W-1 -: AMP_W];
                            res.amp_b     = r_state.held_amps[2*AMP_W-1 -: AMP_W];
                            res.amp_c     = r_state.held_amps[AMP_W-1:0];
                            res.run_ticks = '0;
                            res.last      = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        n_state = nb_state;
                        emit    = nb_emit;
                        if (nb_emit && nb_result.last) begin
                            n_phase  = PH_IDLE;
                            consume  = 1'b1;
                            n_nib_lo = 1'b0;
                        end else if (r_nib_lo) begin
                            consume  = 1'b1;
                            n_nib_lo = 1'b0;
                        end else begin
                            n_nib_lo = 1'b1;
                        end
                    end
                    default: begin
                        consume = 1'b1;
                    end
                endcase
            end
        end
    end

    assign i_in.ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_nib_lo     <= 1'b0;
            r_phase      <= PH_IDLE;
            r_count_high <= '0;
            r_table_sel  <= 1'b0;
            r_state      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_count_high <= n_count_high;
            r_table_sel  <= n_table_sel;
            r_state      <= n_state;
            r_nib_lo     <= n_nib_lo;

            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_start <= i_in.start_req;
            r_loud  <= i_in.loud;
            r_byte  <= i_in.data_byte;
        end
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.amp_a     = r_out.amp_a;
    assign o_out.amp_b     = r_out.amp_b;
    assign o_out.amp_c     = r_out.amp_c;
    assign o_out.run_ticks = r_out.run_ticks;
    assign o_out.last      = r_out.last;

endmodule
